### rtl/aessb_pkg.sv
// aessb_pkg: shared types, constants and GF(2^8) functions for the AES S-box unit.
// Used by every module under rtl; no dependencies.
package aessb_pkg;

   typedef logic [7:0] byte_type;

   typedef enum logic {
      OP_FORWARD = 1'b0,
      OP_INVERSE = 1'b1
   } op_type;

   localparam byte_type REDUCE_POLY      = 8'h1B;
   localparam byte_type AFFINE_CONST     = 8'h63;
   localparam byte_type INV_AFFINE_CONST = 8'h05;

   localparam byte_type AFFINE_ROWS [8] = '{
      8'hF8, 8'h7C, 8'h3E, 8'h1F, 8'h8F, 8'hC7, 8'hE3, 8'hF1
   };

   // stage 1 -> stage 2: x^2 and x^3
   typedef struct packed {
      logic     op;
      byte_type a2;
      byte_type a3;
   } pre_data_type;

   // stage 3 -> stage 4: x^254
   typedef struct packed {
      logic     op;
      byte_type inv;
   } exp_data_type;

   function automatic byte_type gf_double(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? REDUCE_POLY : 8'h00);
   endfunction

   function automatic byte_type gf_mul(input byte_type a, input byte_type b);
      byte_type acc;
      byte_type sh;
      acc = '0;
      sh  = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ sh;
         end
         sh = gf_double(sh);
      end
      return acc;
   endfunction

   function automatic byte_type gf_sq(input byte_type a);
      return gf_mul(a, a);
   endfunction

   function automatic byte_type affine_fwd(input byte_type b);
      byte_type r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[3'(7 - i)] = ^(b & AFFINE_ROWS[i]);
      end
      return r ^ AFFINE_CONST;
   endfunction

   // rotl 1 ^ rotl 3 ^ rotl 6 ^ 0x05
   function automatic byte_type affine_inv(input byte_type b);
      return {b[6:0], b[7]} ^ {b[4:0], b[7:5]} ^ {b[1:0], b[7:2]} ^ INV_AFFINE_CONST;
   endfunction

endpackage

### rtl/aessb_pre.sv
// aessb_pre: first pipeline stage; inverse affine select, then x^2 and x^3.
// Depends on aessb_pkg.
module aessb_pre
   import aessb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic         in_op,
   input  byte_type     in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output pre_data_type out_data
);

   logic         valid_ff;
   logic         valid_in;
   pre_data_type data_ff;
   pre_data_type data_in;
   byte_type     x;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      x          = (in_op == OP_INVERSE) ? affine_inv(in_data) : in_data;
      data_in.op = in_op;
      data_in.a2 = gf_sq(x);
      data_in.a3 = gf_mul(data_in.a2, x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/aessb_exp.sv
// aessb_exp: stages 2 and 3 of the x^254 chain (x^14, x^15, then x^240 * x^14).
// Depends on aessb_pkg.
module aessb_exp
   import aessb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  pre_data_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output exp_data_type out_data
);

   logic         s2_valid_ff;
   logic         s2_valid_in;
   logic         s2_op_ff;
   byte_type     s2_a14_ff;
   byte_type     s2_a15_ff;
   byte_type     a12;
   byte_type     a14;
   byte_type     a15;
   logic         s3_ready;
   logic         s3_valid_ff;
   logic         s3_valid_in;
   exp_data_type s3_data_ff;
   exp_data_type s3_data_in;
   byte_type     a240;

   assign in_ready    = !s2_valid_ff || s3_ready;
   assign s2_valid_in = in_ready ? in_valid : s2_valid_ff;
   assign s3_ready    = !s3_valid_ff || out_ready;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_comb begin
      a12 = gf_sq(gf_sq(in_data.a3));
      a15 = gf_mul(a12, in_data.a3);
      a14 = gf_mul(a12, in_data.a2);
   end

   always_comb begin
      a240           = gf_sq(gf_sq(gf_sq(gf_sq(s2_a15_ff))));
      s3_data_in.op  = s2_op_ff;
      s3_data_in.inv = gf_mul(a240, s2_a14_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s2_op_ff  <= in_data.op;
         s2_a14_ff <= a14;
         s2_a15_ff <= a15;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

### rtl/aessb_post.sv
// aessb_post: output stage; forward affine for forward transactions, result register.
// Depends on aessb_pkg.
module aessb_post
   import aessb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  exp_data_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output byte_type     out_data
);

   logic     valid_ff;
   logic     valid_in;
   byte_type data_ff;
   byte_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign data_in  = (in_data.op == OP_INVERSE) ? in_data.inv : affine_fwd(in_data.inv);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/aes_sbox_forward_inverse_unit.sv
// Top level of the arithmetic AES S-box / inverse S-box unit (no lookup table).
// Instantiates aessb_pre, aessb_exp and aessb_post; depends on aessb_pkg.
//
// One byte per transaction: req_op = 0 gives the forward S-box, 1 the inverse S-box.
// The field inverse is x^254 over GF(2^8) mod 0x11B (zero maps to zero), built as
// an addition chain with three multiplier levels, each in its own register stage,
// plus a final stage for the forward affine map. A new transaction is taken every
// cycle while rsp_ready does not stall the pipeline. Each transaction passes through
// the four register stages in turn (aessb_pre, stages 2 and 3 in aessb_exp, then
// aessb_post) before rsp_valid rises. A stall on rsp_ready backs up stage by stage, so
// up to four transactions are held in flight without loss. The unit keeps no other state.
module aes_sbox_forward_inverse_unit
   import aessb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [7:0] req_data_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_out
);

   logic         pre_valid;
   logic         pre_ready;
   pre_data_type pre_data;
   logic         exp_valid;
   logic         exp_ready;
   exp_data_type exp_data;

   aessb_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_op     (req_op),
      .in_data   (req_data_in),
      .out_valid (pre_valid),
      .out_ready (pre_ready),
      .out_data  (pre_data)
   );

   aessb_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid),
      .in_ready  (pre_ready),
      .in_data   (pre_data),
      .out_valid (exp_valid),
      .out_ready (exp_ready),
      .out_data  (exp_data)
   );

   aessb_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (exp_valid),
      .in_ready  (exp_ready),
      .in_data   (exp_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data_out)
   );

   // input only backs up when every stage is full and the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (pre_valid && exp_valid && rsp_valid && !rsp_ready))
      else $error("req_ready low with a bubble in the pipeline");

   // a stalled first stage keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (pre_valid && !pre_ready) |=> (pre_valid && $stable(pre_data)))
      else $error("stage 1 transaction lost or changed under stall");

   // a stalled third stage keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (exp_valid && !exp_ready) |=> (exp_valid && $stable(exp_data)))
      else $error("stage 3 transaction lost or changed under stall");

   // output drains when taken with nothing behind it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !exp_valid) |=> !rsp_valid)
      else $error("result repeated after acceptance");

endmodule

### tb/aes_sbox_forward_inverse_unit_test.sv
// Self-checking testbench for aes_sbox_forward_inverse_unit: directed table, then random bytes.
// Checks each rsp byte against the table or a local GF(2^8) S-box calculation, both directions.
// Depends on aessb_pkg (byte_type, op_type) and the RTL under rtl/.
module aes_sbox_forward_inverse_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import aessb_pkg::*;

   localparam int       RANDOM_ITEMS   = 1850;
   localparam int       IDLE_PCT       = 37;
   localparam int       CALM_FIRST     = 700;
   localparam int       CALM_LAST      = 1000;
   localparam byte_type FIELD_POLY     = 8'h1B;
   localparam byte_type SBOX_CONST     = 8'h63;
   localparam byte_type INV_SBOX_CONST = 8'h05;

   typedef struct packed {
      op_type   op;
      byte_type din;
      logic     known;
      byte_type dout;
   } sbox_vector_type;

   localparam int NUM_VECTORS = 20;
   sbox_vector_type vectors [NUM_VECTORS] = '{
      '{OP_FORWARD, 8'h00, 1'b1, 8'h63},
      '{OP_FORWARD, 8'h01, 1'b1, 8'h7C},
      '{OP_FORWARD, 8'hFF, 1'b1, 8'h16},
      '{OP_FORWARD, 8'h80, 1'b1, 8'hCD},
      '{OP_FORWARD, 8'h7F, 1'b1, 8'hD2},
      '{OP_FORWARD, 8'h53, 1'b1, 8'hED},
      '{OP_INVERSE, 8'h63, 1'b1, 8'h00},
      '{OP_INVERSE, 8'h7C, 1'b1, 8'h01},
      '{OP_INVERSE, 8'h16, 1'b1, 8'hFF},
      '{OP_INVERSE, 8'hCD, 1'b1, 8'h80},
      '{OP_INVERSE, 8'h00, 1'b1, 8'h52},
      '{OP_INVERSE, 8'hFF, 1'b1, 8'h7D},
      '{OP_FORWARD, 8'h55, 1'b0, 8'h00},
      '{OP_FORWARD, 8'hAA, 1'b0, 8'h00},
      '{OP_FORWARD, 8'h02, 1'b0, 8'h00},
      '{OP_INVERSE, 8'h55, 1'b0, 8'h00},
      '{OP_INVERSE, 8'hAA, 1'b0, 8'h00},
      '{OP_INVERSE, 8'h80, 1'b0, 8'h00},
      '{OP_INVERSE, 8'h01, 1'b0, 8'h00},
      '{OP_INVERSE, 8'h7F, 1'b0, 8'h00}
   };

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic       req_op      = 1'b0;
   logic [7:0] req_data_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b1;
   logic [7:0] rsp_data_out;

   byte_type   req_expect  = 8'h00;
   byte_type   sbox_expect_q [$];
   byte_type   expected_byte;
   bit         calm        = 1'b0;
   int         mismatches  = 0;

   aes_sbox_forward_inverse_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out)
   );

   function automatic byte_type rotl(byte_type v, int unsigned n);
      logic [15:0] twice;
      twice = {v, v} >> (8 - n);
      return twice[7:0];
   endfunction

   function automatic byte_type gf_product(byte_type a, byte_type b);
      byte_type acc;
      byte_type sh;
      acc = '0;
      sh  = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ sh;
         end
         sh = {sh[6:0], 1'b0} ^ (sh[7] ? FIELD_POLY : 8'h00);
      end
      return acc;
   endfunction

   // x^254: inverse for nonzero x, zero for zero
   function automatic byte_type gf_reciprocal(byte_type x);
      byte_type r;
      byte_type sq;
      r  = 8'h01;
      sq = x;
      for (int k = 1; k < 8; k++) begin
         sq = gf_product(sq, sq);
         r  = gf_product(r, sq);
      end
      return r;
   endfunction

   function automatic byte_type substituted_byte(op_type op, byte_type din);
      byte_type t;
      if (op == OP_FORWARD) begin
         t = gf_reciprocal(din);
         return t ^ rotl(t, 1) ^ rotl(t, 2) ^ rotl(t, 3) ^ rotl(t, 4) ^ SBOX_CONST;
      end
      t = rotl(din, 1) ^ rotl(din, 3) ^ rotl(din, 6) ^ INV_SBOX_CONST;
      return gf_reciprocal(t);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer(op_type op, byte_type din, byte_type dout);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_data_in <= din;
      req_expect  <= dout;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= reset || calm || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sbox_expect_q.push_back(req_expect);
         end
         if (rsp_valid && rsp_ready) begin
            if (sbox_expect_q.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %02h",
                        $time, rsp_data_out);
               mismatches++;
            end else begin
               expected_byte = sbox_expect_q.pop_front();
               if (rsp_data_out !== expected_byte) begin
                  $display("%0t: data_out mismatch, expected %02h, actual %02h",
                           $time, expected_byte, rsp_data_out);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      op_type   op;
      byte_type din;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (vectors[i]) begin
         offer(vectors[i].op, vectors[i].din,
               vectors[i].known ? vectors[i].dout
                                : substituted_byte(vectors[i].op, vectors[i].din));
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= CALM_FIRST) && (i < CALM_LAST);
         op   = op_type'($urandom_range(1));
         din  = byte_type'($urandom_range(255));
         offer(op, din, substituted_byte(op, din));
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      while (sbox_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("aes_sbox_forward_inverse_unit_test passed");
      end else begin
         $display("aes_sbox_forward_inverse_unit_test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("aes_sbox_forward_inverse_unit_test failed");
      $finish;
   end

endmodule
